FILE: rtl/core/kab_pkg.sv
// ----------------------------------------------------------------------------
// kab_pkg
// Shared types, widths and helpers of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kab_pkg;

  localparam int KAB_DATA_WIDTH = 32;
  localparam int CFG_W          = 30;
  localparam int CFG_IDX_W      = 2;
  localparam int MUL_A_W        = 33;
  localparam int MUL_B_W        = 34;
  localparam int DIV_STEPS      = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 30'd1073742;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 30'd3221225;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 30'd32212255;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RATE, ST_ANG, ST_STEP, ST_INNER, ST_PAA, ST_PBB, ST_YS,
    ST_DIV0, ST_DIV1, ST_UA, ST_UB, ST_CBA, ST_CAA, ST_CBB, ST_CAB, ST_OUT
  } kab_state_t;

  typedef struct packed {
    logic neg;     // subtract the product from the accumulator
    logic frac30;  // shift by 30, else by 16
    logic sat_dw;  // saturate to DATA_WIDTH, else to 32 bits
  } kab_mac_ctl_t;

  function automatic logic [31:0] sat33to32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else                r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/kab_if.sv
// ----------------------------------------------------------------------------
// kab_if
// Valid/ready channels carrying sensor words in and filter words out.
// ----------------------------------------------------------------------------
interface kab_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] measured_rate;
  logic [15:0]        time_step;

  modport source (output valid, measured_angle, measured_rate, time_step, input ready);
  modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface kab_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] corrected_rate;
  logic signed [31:0] bias_estimate_out;

  modport source (output valid, filtered_angle, corrected_rate, bias_estimate_out,
                  input ready);
  modport sink   (input valid, filtered_angle, corrected_rate, bias_estimate_out,
                  output ready);
endinterface

FILE: rtl/core/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state angle/gyro-bias Kalman filter on a shared MAC and serial divider.
//
//   channel  dir  payload                                             handshake
//   in_if    in   measured_angle, measured_rate, time_step            valid/ready
//   out_if   out  filtered_angle, corrected_rate, bias_estimate_out   valid/ready
//   cfg_*    in   cfg_index, cfg_wdata                                cfg_we
//
// Each word passes from accept to result load through the accept state, 10 MAC
// ops, two gain divisions (cut short when the gain saturates) and the RATE,
// INNER, YS and OUT sequencing states. With a non-positive innovation variance
// the divisions are skipped.
// Ready is high only in idle; a new word is taken while the last result waits.
// Synchronous reset clears the estimates and covariance, loads default noise.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter import kab_pkg::*; #(
  parameter int DATA_WIDTH = KAB_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  kab_in_if.sink               in_if,
  kab_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int ACC_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int DW1   = ACC_W + 1;
  localparam logic signed [DW1-1:0] S32_HI = (DW1'(1) <<< 31) - DW1'(1);
  localparam logic signed [DW1-1:0] S32_LO = -S32_HI - DW1'(1);

  function automatic logic [31:0] sat_to32(input logic signed [DW1-1:0] v);
    logic [31:0] r;
    if (v > S32_HI)      r = 32'h7fff_ffff;
    else if (v < S32_LO) r = 32'h8000_0000;
    else                 r = v[31:0];
    return r;
  endfunction

  kab_state_t state_r, state_nxt;
  logic       phase_r, phase_nxt;

  logic [CFG_W-1:0] qa_r, qb_r, rn_r;

  logic signed [DATA_WIDTH-1:0] angle_r, bias_r;
  logic signed [31:0] caa_r, cab_r, cba_r, cbb_r;
  logic signed [31:0] z_r, w_r, rate_r, step_r, y_r, k0_r, k1_r;
  logic [15:0]        dt_r;
  logic signed [33:0] inner_r;
  logic [31:0]        s_r;

  logic signed [31:0] out_fa_r, out_cr_r, out_be_r;
  logic               out_valid_r;
  logic               out_load;

  logic                      mac_go;
  kab_mac_ctl_t              mac_ctl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_acc;
  logic signed [ACC_W-1:0]   mac_res;

  logic               div_go;
  logic signed [31:0] div_num;
  logic signed [31:0] div_quo;
  logic               div_done;

  logic signed [DW1-1:0] rate_diff, y_diff, angle_ext, bias_ext;
  logic signed [33:0]    inner_sum;
  logic signed [32:0]    s_sum, cab_diff, cba_diff;
  logic                  s_pos;
  logic signed [MUL_A_W-1:0] dt_a;
  logic signed [MUL_B_W-1:0] dt_b;

  kab_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk (clk), .go (mac_go), .ctl (mac_ctl),
    .a (mac_a), .b (mac_b), .acc (mac_acc), .res (mac_res)
  );

  kab_div u_div (
    .clk (clk), .rst_n (rst_n), .go (div_go),
    .num (div_num), .den (s_r), .quo (div_quo), .done (div_done)
  );

  always_comb begin
    rate_diff = DW1'(w_r) - DW1'(bias_r);
    y_diff    = DW1'(z_r) - DW1'(angle_r);
    angle_ext = DW1'(angle_r);
    bias_ext  = DW1'(bias_r);
    inner_sum = 34'(step_r) - 34'(cab_r) - 34'(cba_r) + signed'({4'b0, qa_r});
    cab_diff  = 33'(cab_r) - 33'(step_r);
    cba_diff  = 33'(cba_r) - 33'(step_r);
    s_sum     = 33'(caa_r) + signed'({3'b0, rn_r});
    s_pos     = !s_sum[32] && (s_sum != '0);
    dt_a      = signed'(MUL_A_W'(dt_r));
    dt_b      = signed'(MUL_B_W'(dt_r));
  end

  // sequencer and shared-unit operand select
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mac_go    = 1'b0;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    mac_acc   = '0;
    div_go    = 1'b0;
    div_num   = caa_r;
    out_load  = 1'b0;
    in_if.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) state_nxt = ST_RATE;
      end
      ST_RATE:  state_nxt = ST_ANG;
      ST_INNER: state_nxt = ST_PAA;
      ST_YS:    state_nxt = s_pos ? ST_DIV0 : ST_UA;
      ST_DIV0, ST_DIV1: begin
        div_num = (state_r == ST_DIV0) ? caa_r : cba_r;
        if (!phase_r) begin
          div_go    = 1'b1;
          phase_nxt = 1'b1;
        end else if (div_done) begin
          phase_nxt = 1'b0;
          state_nxt = (state_r == ST_DIV0) ? ST_DIV1 : ST_UA;
        end
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_if.ready;
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        mac_go    = !phase_r;
        phase_nxt = !phase_r;
        case (state_r)
          ST_ANG: begin
            mac_a = dt_a; mac_b = MUL_B_W'(rate_r); mac_acc = ACC_W'(angle_r);
            mac_ctl.sat_dw = 1'b1;
          end
          ST_STEP: begin
            mac_a = dt_a; mac_b = MUL_B_W'(cbb_r);
          end
          ST_PAA: begin
            mac_a = dt_a; mac_b = inner_r; mac_acc = ACC_W'(caa_r);
          end
          ST_PBB: begin
            mac_a = signed'(MUL_A_W'(qb_r)); mac_b = dt_b; mac_acc = ACC_W'(cbb_r);
          end
          ST_UA: begin
            mac_a = MUL_A_W'(k0_r); mac_b = MUL_B_W'(y_r); mac_acc = ACC_W'(angle_r);
            mac_ctl.frac30 = 1'b1; mac_ctl.sat_dw = 1'b1;
          end
          ST_UB: begin
            mac_a = MUL_A_W'(k1_r); mac_b = MUL_B_W'(y_r); mac_acc = ACC_W'(bias_r);
            mac_ctl.frac30 = 1'b1; mac_ctl.sat_dw = 1'b1;
          end
          ST_CBA: begin
            mac_a = MUL_A_W'(k1_r); mac_b = MUL_B_W'(caa_r); mac_acc = ACC_W'(cba_r);
            mac_ctl.frac30 = 1'b1; mac_ctl.neg = 1'b1;
          end
          ST_CAA: begin
            mac_a = MUL_A_W'(k0_r); mac_b = MUL_B_W'(caa_r); mac_acc = ACC_W'(caa_r);
            mac_ctl.frac30 = 1'b1; mac_ctl.neg = 1'b1;
          end
          ST_CBB: begin
            mac_a = MUL_A_W'(k1_r); mac_b = MUL_B_W'(cab_r); mac_acc = ACC_W'(cbb_r);
            mac_ctl.frac30 = 1'b1; mac_ctl.neg = 1'b1;
          end
          ST_CAB: begin
            mac_a = MUL_A_W'(k0_r); mac_b = MUL_B_W'(cab_r); mac_acc = ACC_W'(cab_r);
            mac_ctl.frac30 = 1'b1; mac_ctl.neg = 1'b1;
          end
          default: begin
            mac_go    = 1'b0;
            phase_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        endcase
        if (phase_r) begin
          case (state_r)
            ST_ANG:  state_nxt = ST_STEP;
            ST_STEP: state_nxt = ST_INNER;
            ST_PAA:  state_nxt = ST_PBB;
            ST_PBB:  state_nxt = ST_YS;
            ST_UA:   state_nxt = ST_UB;
            ST_UB:   state_nxt = ST_CBA;
            ST_CBA:  state_nxt = ST_CAA;
            ST_CAA:  state_nxt = ST_CBB;
            ST_CBB:  state_nxt = ST_CAB;
            ST_CAB:  state_nxt = ST_OUT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= ANGLE_NOISE_RST;
      qb_r <= BIAS_NOISE_RST;
      rn_r <= MEAS_NOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_NOISE: qa_r <= cfg_wdata;
        CFG_BIAS_NOISE:  qb_r <= cfg_wdata;
        CFG_MEAS_NOISE:  rn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // filter state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      caa_r   <= '0;
      cab_r   <= '0;
      cba_r   <= '0;
      cbb_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            z_r  <= in_if.measured_angle;
            w_r  <= in_if.measured_rate;
            dt_r <= in_if.time_step;
          end
        end
        ST_RATE: rate_r <= sat_to32(rate_diff);
        ST_INNER: begin
          inner_r <= inner_sum;
          cab_r   <= sat33to32(cab_diff);
          cba_r   <= sat33to32(cba_diff);
        end
        ST_YS: begin
          y_r  <= sat_to32(y_diff);
          s_r  <= s_sum[31:0];
          k0_r <= '0;
          k1_r <= '0;
        end
        ST_DIV0: if (phase_r && div_done) k0_r <= div_quo;
        ST_DIV1: if (phase_r && div_done) k1_r <= div_quo;
        ST_ANG:  if (phase_r) angle_r <= mac_res[DATA_WIDTH-1:0];
        ST_STEP: if (phase_r) step_r  <= mac_res[31:0];
        ST_PAA:  if (phase_r) caa_r   <= mac_res[31:0];
        ST_PBB:  if (phase_r) cbb_r   <= mac_res[31:0];
        ST_UA:   if (phase_r) angle_r <= mac_res[DATA_WIDTH-1:0];
        ST_UB:   if (phase_r) bias_r  <= mac_res[DATA_WIDTH-1:0];
        ST_CBA:  if (phase_r) cba_r   <= mac_res[31:0];
        ST_CAA:  if (phase_r) caa_r   <= mac_res[31:0];
        ST_CBB:  if (phase_r) cbb_r   <= mac_res[31:0];
        ST_CAB:  if (phase_r) cab_r   <= mac_res[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fa_r <= sat_to32(angle_ext);
      out_cr_r <= rate_r;
      out_be_r <= sat_to32(bias_ext);
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.filtered_angle    = out_fa_r;
  assign out_if.corrected_rate    = out_cr_r;
  assign out_if.bias_estimate_out = out_be_r;

endmodule

FILE: rtl/core/kab_mac.sv
// ----------------------------------------------------------------------------
// kab_mac
// Shared multiply, round-half-up shift, accumulate and saturate unit.
// Product registered on go; result valid the cycle after.
// ----------------------------------------------------------------------------
module kab_mac import kab_pkg::*; #(
  parameter int DATA_WIDTH = KAB_DATA_WIDTH,
  localparam int ACC_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32
) (
  input  logic                      clk,
  input  logic                      go,
  input  kab_mac_ctl_t              ctl,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  input  logic signed [ACC_W-1:0]   acc,
  output logic signed [ACC_W-1:0]   res
);

  localparam int PW = MUL_A_W + MUL_B_W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HI_DW = (SW'(1) <<< (DATA_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] HI_32 = (SW'(1) <<< 31) - SW'(1);

  logic signed [PW-1:0]  p_r;
  logic signed [ACC_W-1:0] acc_r;
  kab_mac_ctl_t          ctl_r;
  logic signed [PW-1:0]  rnd;
  logic signed [PW-1:0]  term;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  hi;
  logic signed [SW-1:0]  lo;
  logic signed [SW-1:0]  sat;

  always_ff @(posedge clk) begin
    if (go) begin
      p_r   <= PW'(a) * PW'(b);
      acc_r <= acc;
      ctl_r <= ctl;
    end
  end

  always_comb begin
    rnd  = p_r + (ctl_r.frac30 ? (PW'(1) <<< 29) : (PW'(1) <<< 15));
    term = ctl_r.frac30 ? (rnd >>> 30) : (rnd >>> 16);
    sum  = ctl_r.neg ? (SW'(acc_r) - SW'(term)) : (SW'(acc_r) + SW'(term));
    hi   = ctl_r.sat_dw ? HI_DW : HI_32;
    lo   = -hi - SW'(1);
    if (sum > hi)      sat = hi;
    else if (sum < lo) sat = lo;
    else               sat = sum;
    res  = sat[ACC_W-1:0];
  end

endmodule

FILE: rtl/core/kab_div.sv
// ----------------------------------------------------------------------------
// kab_div
// Serial gain divider: (num * 2^30) / den, truncated, saturated to 32 bits.
// One quotient bit per cycle; overflow detected up front.
// ----------------------------------------------------------------------------
module kab_div import kab_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic signed [31:0] quo,
  output logic               done
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic        nbit_r;
  logic [30:0] q_r;
  logic        neg_r;
  logic [31:0] den_r;
  logic [31:0] quo_r;
  logic [31:0] mag;
  logic        ovf;
  logic [32:0] t;
  logic        ge;
  logic [32:0] t_sub;
  logic [30:0] q_nxt;

  always_comb begin
    mag   = num[31] ? 32'(-num) : 32'(num);
    ovf   = {1'b0, mag} >= {den, 1'b0};
    t     = {rem_r, nbit_r};
    ge    = t >= {1'b0, den_r};
    t_sub = t - {1'b0, den_r};
    q_nxt = {q_r[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        neg_r  <= num[31];
        den_r  <= den;
        rem_r  <= {1'b0, mag[31:1]};
        nbit_r <= mag[0];
        q_r    <= '0;
        cnt_r  <= 5'(DIV_STEPS);
        if (ovf) begin
          done_r <= 1'b1;
          quo_r  <= num[31] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= ge ? t_sub[31:0] : t[31:0];
        nbit_r <= 1'b0;
        q_r    <= q_nxt;
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= neg_r ? -{1'b0, q_nxt} : {1'b0, q_nxt};
        end
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

FILE: rtl/core/kab_checker.sv
// ----------------------------------------------------------------------------
// kab_checker
// Port-level checks of the filter's handshakes and reset, bound to the top level.
// ----------------------------------------------------------------------------
module kab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_filtered_angle,
  input logic [31:0] out_bias_estimate_out
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_filtered_angle)
                                   && $stable(out_bias_estimate_out)))
    else $error("stalled output word changed");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind kalman_angle_bias_filter kab_checker u_kab_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_if.valid),
  .in_ready              (in_if.ready),
  .out_valid             (out_if.valid),
  .out_ready             (out_if.ready),
  .out_filtered_angle    (out_if.filtered_angle),
  .out_bias_estimate_out (out_if.bias_estimate_out)
);
